// ===== sv/spq_pkg.sv =====
package spq_pkg;

   // Queue geometry.
   localparam int DEPTH = 16;
   localparam int OCC_W = $clog2(DEPTH + 1);

   // Fixed field widths.
   localparam int ID_W = 16;
   localparam int PRIO_W = 8;
   localparam int STAMP_W = 32;
   localparam int STATUS_W = 2;
   localparam int OCC_OUT_W = 5;
   localparam int LIMIT_W = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

   // Common width for comparing occupancy against the configured limit.
   localparam int CMP_W = (OCC_W > OCC_OUT_W) ? OCC_W : OCC_OUT_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CAPACITY_LIMIT = CSR_ADDR_W'(0);

   // Request kinds.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // Operation broadcast to every cell.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } cell_op_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PRIO_W-1:0]  prio;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
   } cell_ctrl_type;

endpackage

// ===== sv/spq_if.sv =====
// Request channel: one beat is an insert or a remove.
interface spq_req_if import spq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [ID_W-1:0]    entry_id;
   logic [PRIO_W-1:0]  entry_priority;
   logic [STAMP_W-1:0] arrival_stamp;

   modport source (output valid, kind, entry_id, entry_priority, arrival_stamp,
                   input ready);
   modport sink (input valid, kind, entry_id, entry_priority, arrival_stamp,
                 output ready);
endinterface

// Response channel: one beat per request.
interface spq_rsp_if import spq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [ID_W-1:0]      head_id;
   logic [PRIO_W-1:0]    head_priority;
   logic [STAMP_W-1:0]   head_stamp;
   logic [OCC_OUT_W-1:0] occupancy_now;

   modport source (output valid, status, head_id, head_priority, head_stamp,
                   occupancy_now, input ready);
   modport sink (input valid, status, head_id, head_priority, head_stamp,
                 occupancy_now, output ready);
endinterface

// ===== sv/spq_csr.sv =====
module spq_csr import spq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [LIMIT_W-1:0]    capacity_limit
);

   logic [LIMIT_W-1:0] limit_ff;
   logic [LIMIT_W-1:0] limit_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Capacity limit register; writes to other addresses are dropped.
   always_comb begin
      limit_in = limit_ff;
      if (wr_en && (csr_paddr == ADDR_CAPACITY_LIMIT)) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Read back.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_CAPACITY_LIMIT) begin
         csr_prdata = CSR_DATA_W'(limit_ff);
      end
   end

   assign capacity_limit = limit_ff;

endmodule

// ===== sv/spq_cell.sv =====
module spq_cell import spq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          slot_valid,
   input  entry_type     left_entry,
   input  logic          left_keep,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // True when entry a must be served strictly before entry b.
   function automatic logic goes_before(entry_type a, entry_type b);
      logic result;
      if (a.prio != b.prio) begin
         result = a.prio < b.prio;
      end else begin
         result = a.stamp < b.stamp;
      end
      return result;
   endfunction

   // A held entry stays put on insert unless the new entry ranks ahead of it.
   assign keep = slot_valid && !goes_before(ctrl.new_entry, entry_ff);

   // Hold, take the new entry, shift down from the left, or shift up from the right.
   always_comb begin
      unique case (ctrl.op)
         OP_INSERT: begin
            if (keep) begin
               entry_in = entry_ff;
            end else if (left_keep) begin
               entry_in = ctrl.new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
         OP_REMOVE: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue built as a row of DEPTH cells, the head in cell 0. An insert
// is placed in order (lower priority value first, then smaller arrival stamp, then
// earlier insert) and a remove pops the head; every request returns one response beat
// carrying the status, the removed entry and the occupancy after the request. For each
// request, all cells compare against the new entry in parallel and shift by one place
// at the same edge, so one request is accepted per cycle while the response
// register is empty or being drained. The response is registered. Inserts beyond the
// capacity limit register (saturated at DEPTH) are rejected; removes on an empty queue
// report empty.
module sorted_priority_queue import spq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   spq_req_if.sink               req_ch,
   spq_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [LIMIT_W-1:0]   capacity_limit;
   logic [CMP_W-1:0]     limit_eff;
   logic [CMP_W-1:0]     occ_ext;
   logic [OCC_W-1:0]     occ_ff;
   logic [OCC_W-1:0]     occ_in;
   logic                 accept;
   cell_ctrl_type        ctrl;
   entry_type            cell_entry [DEPTH];
   logic                 cell_keep [DEPTH];

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           status_ff;
   status_type           status_in;
   entry_type            head_ff;
   entry_type            head_in;
   logic [OCC_OUT_W-1:0] occ_out_ff;
   logic [OCC_OUT_W-1:0] occ_out_in;

   spq_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .capacity_limit (capacity_limit)
   );

   // Effective limit saturates at the number of cells.
   assign occ_ext = CMP_W'(occ_ff);
   always_comb begin
      if (CMP_W'(capacity_limit) > CMP_W'(DEPTH)) begin
         limit_eff = CMP_W'(DEPTH);
      end else begin
         limit_eff = CMP_W'(capacity_limit);
      end
   end

   // A new request is taken whenever the response register is free or draining.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;

   // Decode the request into a cell operation and the response beat.
   always_comb begin
      ctrl.op = OP_HOLD;
      ctrl.new_entry.id = req_ch.entry_id;
      ctrl.new_entry.prio = req_ch.entry_priority;
      ctrl.new_entry.stamp = req_ch.arrival_stamp;
      occ_in = occ_ff;
      status_in = status_ff;
      head_in = head_ff;
      if (accept) begin
         head_in = '0;
         if (req_ch.kind == KIND_INSERT) begin
            if (occ_ext >= limit_eff) begin
               status_in = ST_FULL;
            end else begin
               ctrl.op = OP_INSERT;
               occ_in = occ_ff + OCC_W'(1);
               status_in = ST_INSERTED;
            end
         end else begin
            if (occ_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               ctrl.op = OP_REMOVE;
               occ_in = occ_ff - OCC_W'(1);
               status_in = ST_REMOVED;
               head_in = cell_entry[0];
            end
         end
      end
   end

   assign occ_out_in = accept ? OCC_OUT_W'(occ_in) : occ_out_ff;

   // Response valid: set by an accepted request, cleared when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Row of cells; cell 0 is the head, shifts run toward the tail on insert.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_keep;
      entry_type right_entry;
      logic      slot_valid;

      assign slot_valid = occ_ff > OCC_W'(i);

      if (i == 0) begin : g_head
         assign left_entry = cell_entry[0];
         assign left_keep = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_keep = cell_keep[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .slot_valid  (slot_valid),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i])
      );
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      head_ff <= head_in;
      occ_out_ff <= occ_out_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.head_id = head_ff.id;
   assign rsp_ch.head_priority = head_ff.prio;
   assign rsp_ch.head_stamp = head_ff.stamp;
   assign rsp_ch.occupancy_now = occ_out_ff;

endmodule
